[rtl/bis_pkg.sv]
`timescale 1ns / 1ps

package bis_pkg;

   // frame geometry and fixed point format
   localparam int unsigned MAX_WIDTH  = 512;
   localparam int unsigned MAX_HEIGHT = 512;
   localparam int unsigned FRAC_BITS  = 12;

   // field widths
   localparam int unsigned COORD_W   = 12;
   localparam int unsigned CHAN_W    = 8;
   localparam int unsigned NUM_CH    = 3;
   localparam int unsigned PIXEL_W   = CHAN_W * NUM_CH;
   localparam int unsigned SCALE_W   = 16;
   localparam int unsigned DIM_W     = 10;
   localparam int unsigned CSR_IDX_W = 2;

   // frame store addressing: {row, col}
   localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
   localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT);
   localparam int unsigned ADDR_W = COL_W + ROW_W;
   localparam int unsigned DEPTH  = 2 ** ADDR_W;

   // arithmetic widths
   localparam int unsigned PROD_W = COORD_W + SCALE_W;
   localparam int unsigned IX_W   = PROD_W - FRAC_BITS;
   localparam int unsigned WGT_W  = FRAC_BITS + 1;
   localparam int unsigned H_W    = CHAN_W + FRAC_BITS;
   localparam int unsigned V_W    = CHAN_W + 2 * FRAC_BITS;

   // configuration register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERSE_SCALE = 2'd2;

   localparam logic [DIM_W-1:0]   RESET_WIDTH   = 10'd512;
   localparam logic [DIM_W-1:0]   RESET_HEIGHT  = 10'd512;
   localparam logic [SCALE_W-1:0] RESET_INVERSE = 16'd8192;

   // request opcodes
   localparam logic OP_STORE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [1:0] {
      TAP_A,
      TAP_B,
      TAP_C,
      TAP_D
   } tap_type;

   localparam int unsigned NUM_TAPS = 4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_READ,
      ST_DRAIN,
      ST_HORZ,
      ST_VERT
   } state_type;

   // last valid index of a dimension: zero acts as one, oversize saturates
   function automatic logic [COORD_W-1:0] last_index(input logic [DIM_W-1:0] v,
                                                     input int unsigned limit);
      logic [COORD_W-1:0] r;
      if (v == '0) begin
         r = '0;
      end else if (int'(v) > limit) begin
         r = COORD_W'(limit - 1);
      end else begin
         r = COORD_W'(v - 1'b1);
      end
      return r;
   endfunction

endpackage

[rtl/bis_ram.sv]
`timescale 1ns / 1ps

module bis_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/bilinear_rgb_image_scaler.sv]
`timescale 1ns / 1ps
// store requests are accepted back to back while no query is in progress
// a query steps from its accept through a clamp step, four reads of the single-port
// frame memory, a drain step for the registered read, a horizontal and a vertical
// blend step; no new request is taken until it is done, the vertical step holds while
// an older result is stalled, and the result is registered at the end of that step
// reset idles control, loads config defaults; frame memory is undefined until written

module bilinear_rgb_image_scaler (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_opcode,
   input  logic [bis_pkg::COORD_W-1:0]     req_pixel_col,
   input  logic [bis_pkg::COORD_W-1:0]     req_pixel_row,
   input  logic [bis_pkg::CHAN_W-1:0]      req_in_red,
   input  logic [bis_pkg::CHAN_W-1:0]      req_in_green,
   input  logic [bis_pkg::CHAN_W-1:0]      req_in_blue,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bis_pkg::CHAN_W-1:0]      rsp_out_red,
   output logic [bis_pkg::CHAN_W-1:0]      rsp_out_green,
   output logic [bis_pkg::CHAN_W-1:0]      rsp_out_blue,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bis_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bis_pkg::SCALE_W-1:0]     csr_data
);

   import bis_pkg::*;

   localparam logic [FRAC_BITS:0] ONE = WGT_W'(1) << FRAC_BITS;

   state_type state_ff, state_in;

   // configuration
   logic [COL_W-1:0]   last_col_ff, last_col_in;
   logic [ROW_W-1:0]   last_row_ff, last_row_in;
   logic [SCALE_W-1:0] inv_scale_ff, inv_scale_in;

   // query datapath
   logic [PROD_W-1:0]    sx_ff, sy_ff;
   logic [COL_W-1:0]     x0_ff, x1_ff;
   logic [ROW_W-1:0]     y0_ff, y1_ff;
   logic [FRAC_BITS-1:0] fx_ff, fy_ff;
   logic [COL_W-1:0]     x0_in, x1_in;
   logic [ROW_W-1:0]     y0_in, y1_in;
   logic [IX_W-1:0]      ix, iy;

   tap_type              rd_cnt_ff, cap_idx_ff;
   logic                 cap_valid_ff;
   logic [PIXEL_W-1:0]   pix_ff [NUM_TAPS];
   logic [H_W-1:0]       top_ff [NUM_CH];
   logic [H_W-1:0]       bot_ff [NUM_CH];
   logic [H_W-1:0]       top_in [NUM_CH];
   logic [H_W-1:0]       bot_in [NUM_CH];
   logic [CHAN_W-1:0]    res    [NUM_CH];

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0]    rsp_red_ff, rsp_green_ff, rsp_blue_ff;

   // memory port
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_addr, rd_addr;
   logic [PIXEL_W-1:0]   mem_rdata;

   logic                 store_ok, query_acc, rsp_free, rsp_load;
   logic [WGT_W-1:0]     wx0, wy0;

   bis_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (DEPTH)
   ) u_frame (
      .clock   (clock),
      .wr_en   (mem_we),
      .addr    (mem_addr),
      .wr_data ({req_in_red, req_in_green, req_in_blue}),
      .rd_data (mem_rdata)
   );

   // ------------------------------------------------------------ config port
   assign csr_ready = 1'b1;

   always_comb begin
      last_col_in  = last_col_ff;
      last_row_in  = last_row_ff;
      inv_scale_in = inv_scale_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               last_col_in = COL_W'(last_index(csr_data[DIM_W-1:0], MAX_WIDTH));
            end
            CSR_IMAGE_HEIGHT: begin
               last_row_in = ROW_W'(last_index(csr_data[DIM_W-1:0], MAX_HEIGHT));
            end
            CSR_INVERSE_SCALE: begin
               inv_scale_in = csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff  <= COL_W'(last_index(RESET_WIDTH, MAX_WIDTH));
         last_row_ff  <= ROW_W'(last_index(RESET_HEIGHT, MAX_HEIGHT));
         inv_scale_ff <= RESET_INVERSE;
      end else begin
         last_col_ff  <= last_col_in;
         last_row_ff  <= last_row_in;
         inv_scale_ff <= inv_scale_in;
      end
   end

   // ------------------------------------------------------------ control
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_opcode == OP_QUERY) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: state_in = ST_READ;
         ST_READ: begin
            if (rd_cnt_ff == TAP_D) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_HORZ;
         ST_HORZ:  state_in = ST_VERT;
         ST_VERT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign store_ok = ({1'b0, req_pixel_col} < (COORD_W + 1)'(MAX_WIDTH)) &&
                     ({1'b0, req_pixel_row} < (COORD_W + 1)'(MAX_HEIGHT));

   always_comb begin
      req_stall = 1'b1;
      mem_we    = 1'b0;
      mem_addr  = {req_pixel_row[ROW_W-1:0], req_pixel_col[COL_W-1:0]};
      query_acc = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            mem_we    = req_valid && req_opcode == OP_STORE && store_ok;
            query_acc = req_valid && req_opcode == OP_QUERY;
         end
         ST_READ: begin
            mem_addr = rd_addr;
         end
         ST_VERT: begin
            rsp_load = rsp_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_cnt_ff    <= TAP_A;
         cap_valid_ff <= 1'b0;
         cap_idx_ff   <= TAP_A;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_cnt_ff    <= (state_ff == ST_READ) ? tap_type'(rd_cnt_ff + 1'b1) : TAP_A;
         cap_valid_ff <= (state_ff == ST_READ);
         cap_idx_ff   <= rd_cnt_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ------------------------------------------------------------ source mapping
   always_ff @(posedge clock) begin
      if (query_acc) begin
         sx_ff <= PROD_W'(req_pixel_col) * PROD_W'(inv_scale_ff);
         sy_ff <= PROD_W'(req_pixel_row) * PROD_W'(inv_scale_ff);
      end
   end

   assign ix = sx_ff[PROD_W-1:FRAC_BITS];
   assign iy = sy_ff[PROD_W-1:FRAC_BITS];

   // clamp to the last column/row; there the far neighbor repeats the near one
   always_comb begin
      x0_in = (ix > IX_W'(last_col_ff)) ? last_col_ff : ix[COL_W-1:0];
      y0_in = (iy > IX_W'(last_row_ff)) ? last_row_ff : iy[ROW_W-1:0];
      x1_in = (x0_in == last_col_ff) ? x0_in : x0_in + 1'b1;
      y1_in = (y0_in == last_row_ff) ? y0_in : y0_in + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLAMP) begin
         x0_ff <= x0_in;
         x1_ff <= x1_in;
         y0_ff <= y0_in;
         y1_ff <= y1_in;
         fx_ff <= sx_ff[FRAC_BITS-1:0];
         fy_ff <= sy_ff[FRAC_BITS-1:0];
      end
   end

   // ------------------------------------------------------------ neighbor reads
   always_comb begin
      case (rd_cnt_ff)
         TAP_A:   rd_addr = {y0_ff, x0_ff};
         TAP_B:   rd_addr = {y0_ff, x1_ff};
         TAP_C:   rd_addr = {y1_ff, x0_ff};
         TAP_D:   rd_addr = {y1_ff, x1_ff};
         default: rd_addr = {y0_ff, x0_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (cap_valid_ff) begin
         pix_ff[cap_idx_ff] <= mem_rdata;
      end
   end

   // ------------------------------------------------------------ blend
   assign wx0 = ONE - WGT_W'(fx_ff);
   assign wy0 = ONE - WGT_W'(fy_ff);

   // separable form: horizontal pass on each of the two rows, then vertical; sums exact, result truncated
   always_comb begin
      for (int k = 0; k < NUM_CH; k++) begin
         top_in[k] = H_W'(pix_ff[TAP_A][CHAN_W*(NUM_CH-1-k) +: CHAN_W]) * H_W'(wx0) +
                     H_W'(pix_ff[TAP_B][CHAN_W*(NUM_CH-1-k) +: CHAN_W]) * H_W'(fx_ff);
         bot_in[k] = H_W'(pix_ff[TAP_C][CHAN_W*(NUM_CH-1-k) +: CHAN_W]) * H_W'(wx0) +
                     H_W'(pix_ff[TAP_D][CHAN_W*(NUM_CH-1-k) +: CHAN_W]) * H_W'(fx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_HORZ) begin
         for (int k = 0; k < NUM_CH; k++) begin
            top_ff[k] <= top_in[k];
            bot_ff[k] <= bot_in[k];
         end
      end
   end

   always_comb begin
      logic [V_W-1:0] sum;
      for (int k = 0; k < NUM_CH; k++) begin
         sum    = V_W'(top_ff[k]) * V_W'(wy0) + V_W'(bot_ff[k]) * V_W'(fy_ff);
         res[k] = sum[V_W-1 -: CHAN_W];
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_red_ff   <= res[0];
         rsp_green_ff <= res[1];
         rsp_blue_ff  <= res[2];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_red_ff;
   assign rsp_out_green = rsp_green_ff;
   assign rsp_out_blue  = rsp_blue_ff;

endmodule
